// ===== rtl/core/sorted_key_table_assert.svh =====
// Assertion macros for the sorted key table; clocked on clk_i, disabled in reset.
`ifndef SORTED_KEY_TABLE_ASSERT_SVH
`define SORTED_KEY_TABLE_ASSERT_SVH

// pre in this cycle implies post in the same cycle
`define SKT_ASSERT_IMPL(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// pre in this cycle implies post in the next cycle
`define SKT_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

// cond never holds
`define SKT_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

// ===== rtl/core/skt_pkg.sv =====
// Shared constants for the sorted key table.
`timescale 1ns / 1ps

package skt_pkg;

  localparam int unsigned SKT_CAPACITY = 64;

  localparam int unsigned KIND_W    = 2;
  localparam int unsigned KEY_W     = 32;
  localparam int unsigned POS_W     = 6;
  localparam int unsigned CNT_OUT_W = 7;

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;

endpackage

// ===== rtl/core/skt_if.sv =====
// Request and response channel interfaces of the sorted key table.
`timescale 1ns / 1ps

interface skt_req_if import skt_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic signed [KEY_W-1:0]  key;

  modport source (output valid, output kind, output key, input ready);
  modport sink   (input valid, input kind, input key, output ready);
endinterface

interface skt_rsp_if import skt_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  success;
  logic [POS_W-1:0]      position;
  logic [CNT_OUT_W-1:0]  entry_count;

  modport source (output valid, output success, output position, output entry_count,
                  input ready);
  modport sink   (input valid, input success, input position, input entry_count,
                  output ready);
endinterface

// ===== rtl/core/sorted_key_table.sv =====
// Sorted key table: microcoded insert, binary-search lookup and delete.
//
//   channel  dir  modport  payload
//   req_i    in   sink     kind[1:0], key[31:0] signed
//   rsp_o    out  source   success, position[5:0], entry_count[6:0]
//
// One item at a time. Insert shifts each larger key up by one, then writes the new key.
// Lookup and delete binary-search the table; a hit on delete shifts the keys above it down.
// Slowest item: delete of the lowest key in a full table, set by the one-key-per-cycle shift.
// Reset clears the step, the entry count and the output register; key memory needs no clearing.
// A new request is taken while the previous response still waits in the output register.
`timescale 1ns / 1ps
`include "sorted_key_table_assert.svh"

module sorted_key_table import skt_pkg::*; #(
  parameter int unsigned CAPACITY = SKT_CAPACITY
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  skt_req_if.sink     req_i,
  skt_rsp_if.source   rsp_o
);

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_K0, ST_K1, ST_I0, ST_I1, ST_ISH, ST_IWR, ST_S0, ST_S1, ST_S2,
    ST_LHIT, ST_D0, ST_D1, ST_DEND, ST_FAIL
  } step_e;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_RD_DOWN, OP_SHIFT_UP, OP_INS_DONE, OP_RD_MID, OP_NARROW,
    OP_LOOKUP_DONE, OP_RD_UP, OP_SHIFT_DOWN, OP_DEL_DONE, OP_FAIL_DONE
  } op_e;

  typedef enum logic [3:0] {
    C_ALWAYS, C_ACCEPT, C_IS_INSERT, C_IS_SEARCH, C_IS_LOOKUP, C_FULL, C_PTR_ZERO,
    C_SHIFT_MORE, C_SEARCH_EMPTY, C_HIT, C_DEL_MORE
  } cond_e;

  typedef struct packed {
    op_e   op;
    logic  res;
    cond_e cond;
    step_e jmp_t;
    step_e jmp_f;
  } ctrl_t;

  function automatic ctrl_t ucode(step_e s);
    ctrl_t w;
    unique case (s)
      ST_IDLE: w = '{OP_LOAD,        1'b0, C_ACCEPT,       ST_K0,   ST_IDLE};
      ST_K0:   w = '{OP_NONE,        1'b0, C_IS_INSERT,    ST_I0,   ST_K1};
      ST_K1:   w = '{OP_NONE,        1'b0, C_IS_SEARCH,    ST_S0,   ST_FAIL};
      ST_I0:   w = '{OP_NONE,        1'b0, C_FULL,         ST_FAIL, ST_I1};
      ST_I1:   w = '{OP_RD_DOWN,     1'b0, C_PTR_ZERO,     ST_IWR,  ST_ISH};
      ST_ISH:  w = '{OP_SHIFT_UP,    1'b0, C_SHIFT_MORE,   ST_ISH,  ST_IWR};
      ST_IWR:  w = '{OP_INS_DONE,    1'b1, C_ALWAYS,       ST_IDLE, ST_IDLE};
      ST_S0:   w = '{OP_RD_MID,      1'b0, C_SEARCH_EMPTY, ST_FAIL, ST_S1};
      ST_S1:   w = '{OP_NARROW,      1'b0, C_HIT,          ST_S2,   ST_S0};
      ST_S2:   w = '{OP_NONE,        1'b0, C_IS_LOOKUP,    ST_LHIT, ST_D0};
      ST_LHIT: w = '{OP_LOOKUP_DONE, 1'b1, C_ALWAYS,       ST_IDLE, ST_IDLE};
      ST_D0:   w = '{OP_RD_UP,       1'b0, C_DEL_MORE,     ST_D1,   ST_DEND};
      ST_D1:   w = '{OP_SHIFT_DOWN,  1'b0, C_DEL_MORE,     ST_D1,   ST_DEND};
      ST_DEND: w = '{OP_DEL_DONE,    1'b1, C_ALWAYS,       ST_IDLE, ST_IDLE};
      ST_FAIL: w = '{OP_FAIL_DONE,   1'b1, C_ALWAYS,       ST_IDLE, ST_IDLE};
      default: w = '{OP_NONE,        1'b0, C_ALWAYS,       ST_IDLE, ST_IDLE};
    endcase
    return w;
  endfunction

  logic signed [KEY_W-1:0] mem [CAPACITY];

  step_e                   step_q, step_d;
  logic [CNT_W-1:0]        count_q, count_d;
  logic                    out_valid_q, out_valid_d;
  logic                    succ_q, succ_d;
  logic [POS_W-1:0]        pos_q, pos_d;
  logic [CNT_OUT_W-1:0]    cnt_out_q, cnt_out_d;

  logic [KIND_W-1:0]       kind_q, kind_d;
  logic signed [KEY_W-1:0] key_q, key_d;
  logic [CNT_W-1:0]        lo_q, lo_d;
  logic [CNT_W-1:0]        hi1_q, hi1_d;
  logic [CNT_W-1:0]        ptr_q, ptr_d;
  logic signed [KEY_W-1:0] rdata_q;

  ctrl_t                   ctrl;
  logic                    advance;
  logic                    cond_true;
  logic                    req_fire;
  logic                    res_fire;
  logic [CNT_W:0]          mid_sum;
  logic [CNT_W-1:0]        mid;
  logic                    mem_we;
  logic [IDX_W-1:0]        mem_wa;
  logic signed [KEY_W-1:0] mem_wd;
  logic                    rd_en;
  logic [IDX_W-1:0]        rd_addr;
  logic [CNT_W-1:0]        rd_ptr;
  logic [CNT_W+POS_W-1:0]  ptr_ext;
  logic [CNT_W+CNT_OUT_W-1:0] cnt_ext;

  assign ctrl     = ucode(step_q);
  assign advance  = !(ctrl.res && out_valid_q && !rsp_o.ready);
  assign req_fire = req_i.valid && req_i.ready;
  assign res_fire = advance && ctrl.res;
  assign mid_sum  = {1'b0, lo_q} + {1'b0, hi1_q} - (CNT_W + 1)'(1);
  assign mid      = mid_sum[CNT_W:1];
  assign ptr_ext  = {{POS_W{1'b0}}, ptr_q};
  assign cnt_ext  = {{CNT_OUT_W{1'b0}}, count_d};

  assign req_i.ready       = (step_q == ST_IDLE);
  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.success     = succ_q;
  assign rsp_o.position    = pos_q;
  assign rsp_o.entry_count = cnt_out_q;

  always_comb begin
    kind_d      = kind_q;
    key_d       = key_q;
    lo_d        = lo_q;
    hi1_d       = hi1_q;
    ptr_d       = ptr_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    succ_d      = succ_q;
    pos_d       = pos_q;
    cnt_out_d   = cnt_out_q;
    mem_we      = 1'b0;
    mem_wa      = ptr_q[IDX_W-1:0];
    mem_wd      = key_q;
    rd_en       = 1'b0;
    rd_addr     = '0;
    rd_ptr      = '0;

    if (advance) begin
      case (ctrl.op)
        OP_LOAD: begin
          if (req_i.valid) begin
            kind_d = req_i.kind;
            key_d  = req_i.key;
            lo_d   = '0;
            hi1_d  = count_q;
            ptr_d  = count_q;
          end
        end
        OP_SHIFT_UP: begin
          if (rdata_q > key_q) begin
            mem_we = 1'b1;
            mem_wd = rdata_q;
            ptr_d  = ptr_q - CNT_W'(1);
          end
        end
        OP_INS_DONE: begin
          mem_we  = 1'b1;
          count_d = count_q + CNT_W'(1);
        end
        OP_NARROW: begin
          if (rdata_q == key_q) begin
            ptr_d = mid;
          end else if (rdata_q < key_q) begin
            lo_d = mid + CNT_W'(1);
          end else begin
            hi1_d = mid;
          end
        end
        OP_SHIFT_DOWN: begin
          mem_we = 1'b1;
          mem_wd = rdata_q;
          ptr_d  = ptr_q + CNT_W'(1);
        end
        OP_DEL_DONE: count_d = count_q - CNT_W'(1);
        default: ;
      endcase

      case (ctrl.op)
        OP_RD_DOWN, OP_SHIFT_UP: begin
          rd_en   = 1'b1;
          rd_ptr  = ptr_d - CNT_W'(1);
          rd_addr = rd_ptr[IDX_W-1:0];
        end
        OP_RD_UP, OP_SHIFT_DOWN: begin
          rd_en   = 1'b1;
          rd_ptr  = ptr_d + CNT_W'(1);
          rd_addr = rd_ptr[IDX_W-1:0];
        end
        OP_RD_MID: begin
          rd_en   = 1'b1;
          rd_addr = mid[IDX_W-1:0];
        end
        default: ;
      endcase

      if (ctrl.res) begin
        out_valid_d = 1'b1;
        succ_d      = (ctrl.op != OP_FAIL_DONE);
        pos_d       = (ctrl.op == OP_LOOKUP_DONE) ? ptr_ext[POS_W-1:0] : '0;
        cnt_out_d   = cnt_ext[CNT_OUT_W-1:0];
      end
    end
  end

  always_comb begin
    case (ctrl.cond)
      C_ALWAYS:       cond_true = 1'b1;
      C_ACCEPT:       cond_true = req_i.valid;
      C_IS_INSERT:    cond_true = (kind_q == KIND_INSERT);
      C_IS_SEARCH:    cond_true = (kind_q == KIND_LOOKUP) || (kind_q == KIND_DELETE);
      C_IS_LOOKUP:    cond_true = (kind_q == KIND_LOOKUP);
      C_FULL:         cond_true = (count_q == CNT_W'(CAPACITY));
      C_PTR_ZERO:     cond_true = (ptr_q == '0);
      C_SHIFT_MORE:   cond_true = (rdata_q > key_q) && (ptr_q != CNT_W'(1));
      C_SEARCH_EMPTY: cond_true = (lo_q >= hi1_q);
      C_HIT:          cond_true = (rdata_q == key_q);
      C_DEL_MORE:     cond_true = ({1'b0, ptr_d} + (CNT_W + 1)'(1)) < {1'b0, count_q};
      default:        cond_true = 1'b0;
    endcase
    if (!advance) begin
      step_d = step_q;
    end else if (cond_true) begin
      step_d = ctrl.jmp_t;
    end else begin
      step_d = ctrl.jmp_f;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      succ_q      <= 1'b0;
      pos_q       <= '0;
      cnt_out_q   <= '0;
    end else begin
      step_q      <= step_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      succ_q      <= succ_d;
      pos_q       <= pos_d;
      cnt_out_q   <= cnt_out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    key_q  <= key_d;
    lo_q   <= lo_d;
    hi1_q  <= hi1_d;
    ptr_q  <= ptr_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  `SKT_ASSERT_NEXT(a_accept_dispatch, req_fire, step_q == ST_K0, "accepted item not dispatched")
  `SKT_ASSERT_NEVER(a_no_rsp_overwrite, res_fire && out_valid_q && !rsp_o.ready, "response overwritten")
  `SKT_ASSERT_IMPL(a_search_bounds, step_q == ST_S1, lo_q < hi1_q && hi1_q <= count_q, "search window out of range")
  `SKT_ASSERT_NEXT(a_insert_count, step_q == ST_IWR && advance, count_q == $past(count_q) + CNT_W'(1), "insert did not bump count")
  `SKT_ASSERT_NEVER(a_count_bound, count_q > CNT_W'(CAPACITY), "entry count above capacity")

endmodule

// ===== test/tb.sv =====
// Testbench for sorted_key_table: directed rows and random fill/drain runs checked per item.
`timescale 1ns / 1ps

module tb;
  import skt_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int unsigned N_RANDOM = 900;
  localparam int unsigned N_DIRECTED = 25;

  typedef struct packed {
    logic                 success;
    logic [POS_W-1:0]     position;
    logic [CNT_OUT_W-1:0] entry_count;
  } rsp_t;

  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic signed [KEY_W-1:0] key;
    logic                    typed;
    rsp_t                    want;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic no_stall;

  skt_req_if req ();
  skt_rsp_if rsp ();

  sorted_key_table uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req),
    .rsp_o (rsp)
  );

  // shadow copy of the table
  logic signed [KEY_W-1:0] shadow_keys [SKT_CAPACITY];
  int                      shadow_count;

  rsp_t pending_rsps [$];
  rsp_t oldest_rsp;
  int   err_cnt;

  dir_row_t dir_rows [N_DIRECTED] = '{
    '{KIND_LOOKUP, 32'sh00000000, 1'b1, '{1'b0, 6'd0, 7'd0}},
    '{KIND_DELETE, 32'sh00000000, 1'b1, '{1'b0, 6'd0, 7'd0}},
    '{KIND_UNUSED, 32'sh00000005, 1'b1, '{1'b0, 6'd0, 7'd0}},
    '{KIND_INSERT, 32'sh7fffffff, 1'b1, '{1'b1, 6'd0, 7'd1}},
    '{KIND_INSERT, 32'sh80000000, 1'b1, '{1'b1, 6'd0, 7'd2}},
    '{KIND_LOOKUP, 32'sh80000000, 1'b1, '{1'b1, 6'd0, 7'd2}},
    '{KIND_LOOKUP, 32'sh7fffffff, 1'b1, '{1'b1, 6'd1, 7'd2}},
    '{KIND_LOOKUP, 32'sh00000000, 1'b1, '{1'b0, 6'd0, 7'd2}},
    '{KIND_INSERT, 32'sh00000000, 1'b1, '{1'b1, 6'd0, 7'd3}},
    '{KIND_INSERT, 32'sh00000000, 1'b0, '0},
    '{KIND_INSERT, 32'sh00000000, 1'b0, '0},
    '{KIND_INSERT, 32'shffffffff, 1'b0, '0},
    '{KIND_INSERT, 32'sh00000001, 1'b0, '0},
    '{KIND_LOOKUP, 32'sh00000000, 1'b0, '0},
    '{KIND_LOOKUP, 32'shffffffff, 1'b0, '0},
    '{KIND_LOOKUP, 32'sh00000001, 1'b0, '0},
    '{KIND_UNUSED, 32'shffffffff, 1'b1, '{1'b0, 6'd0, 7'd7}},
    '{KIND_DELETE, 32'sh00000000, 1'b0, '0},
    '{KIND_LOOKUP, 32'sh00000000, 1'b0, '0},
    '{KIND_DELETE, 32'sh00000002, 1'b1, '{1'b0, 6'd0, 7'd6}},
    '{KIND_DELETE, 32'sh7fffffff, 1'b0, '0},
    '{KIND_DELETE, 32'sh80000000, 1'b0, '0},
    '{KIND_DELETE, 32'sh00000000, 1'b0, '0},
    '{KIND_DELETE, 32'sh00000000, 1'b0, '0},
    '{KIND_LOOKUP, 32'sh00000000, 1'b1, '{1'b0, 6'd0, 7'd2}}
  };

  // floor-midpoint binary search, -1 when absent
  function automatic int shadow_search(logic signed [KEY_W-1:0] k);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = shadow_count - 1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (shadow_keys[mid] == k) return mid;
      if (shadow_keys[mid] < k) lo = mid + 1;
      else hi = mid - 1;
    end
    return -1;
  endfunction

  function automatic rsp_t table_apply(logic [KIND_W-1:0] kind, logic signed [KEY_W-1:0] k);
    rsp_t res;
    int   p;
    res = '0;
    case (kind)
      KIND_INSERT: begin
        if (shadow_count < SKT_CAPACITY) begin
          p = shadow_count;
          while (p > 0 && shadow_keys[p-1] > k) begin
            shadow_keys[p] = shadow_keys[p-1];
            p--;
          end
          shadow_keys[p] = k;
          shadow_count++;
          res.success = 1'b1;
        end
      end
      KIND_LOOKUP: begin
        p = shadow_search(k);
        if (p >= 0) begin
          res.success  = 1'b1;
          res.position = p[POS_W-1:0];
        end
      end
      KIND_DELETE: begin
        p = shadow_search(k);
        if (p >= 0) begin
          for (int j = p; j + 1 < shadow_count; j++) shadow_keys[j] = shadow_keys[j+1];
          shadow_count--;
          res.success = 1'b1;
        end
      end
      default: ;
    endcase
    res.entry_count = shadow_count[CNT_OUT_W-1:0];
    return res;
  endfunction

  // hit_pct: chance of reusing a key already held
  function automatic logic signed [KEY_W-1:0] pick_key(int hit_pct);
    int r;
    int v;
    r = $urandom_range(99);
    if (shadow_count > 0 && r < hit_pct) return shadow_keys[$urandom_range(shadow_count - 1)];
    if ($urandom_range(1)) begin
      v = $urandom_range(16);
      return v - 8;
    end
    return $urandom;
  endfunction

  task automatic send_request(input logic [KIND_W-1:0] kind, input logic signed [KEY_W-1:0] k,
                              input logic typed, input rsp_t want);
    rsp_t predicted;
    if (!no_stall && $urandom_range(99) < 9) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.kind  <= kind;
    req.key   <= k;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    predicted = table_apply(kind, k);
    pending_rsps.push_back(typed ? want : predicted);
  endtask

  initial clk = 1'b0;
  always #6 clk = ~clk;

  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(posedge clk);
      rsp.ready <= no_stall || ($urandom_range(99) >= 9);
    end
  end

  always @(posedge clk) begin
    if (rst_n && rsp.valid && rsp.ready) begin
      if (pending_rsps.size() == 0) begin
        $error("unexpected result: success %0d position %0d entry_count %0d",
               rsp.success, rsp.position, rsp.entry_count);
        err_cnt++;
      end else begin
        oldest_rsp = pending_rsps.pop_front();
        if (rsp.success !== oldest_rsp.success) begin
          $error("success: expected %0d, got %0d", oldest_rsp.success, rsp.success);
          err_cnt++;
        end
        if (rsp.position !== oldest_rsp.position) begin
          $error("position: expected %0d, got %0d", oldest_rsp.position, rsp.position);
          err_cnt++;
        end
        if (rsp.entry_count !== oldest_rsp.entry_count) begin
          $error("entry_count: expected %0d, got %0d", oldest_rsp.entry_count,
                 rsp.entry_count);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    logic [KIND_W-1:0]       kind;
    logic signed [KEY_W-1:0] k;
    bit                      filling;
    int                      bound_hits;
    int                      r;

    err_cnt      = 0;
    shadow_count = 0;
    no_stall     = 1'b0;
    req.valid    = 1'b0;
    req.kind     = KIND_INSERT;
    req.key      = '0;
    rst_n        = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i])
      send_request(dir_rows[i].kind, dir_rows[i].key, dir_rows[i].typed, dir_rows[i].want);

    // alternate fill and drain runs so the table hits full and empty repeatedly
    filling    = 1'b1;
    bound_hits = 0;
    for (int i = 0; i < N_RANDOM; i++) begin
      no_stall <= (i >= 300 && i < 450);
      r = $urandom_range(99);
      if (filling)
        kind = (r < 65) ? KIND_INSERT : (r < 80) ? KIND_LOOKUP :
               (r < 96) ? KIND_DELETE : KIND_UNUSED;
      else
        kind = (r < 15) ? KIND_INSERT : (r < 30) ? KIND_LOOKUP :
               (r < 96) ? KIND_DELETE : KIND_UNUSED;
      k = pick_key((kind == KIND_INSERT) ? 10 : (filling ? 40 : 80));
      if (filling && shadow_count == SKT_CAPACITY && kind == KIND_INSERT) bound_hits++;
      if (!filling && shadow_count == 0 && kind != KIND_INSERT) bound_hits++;
      if (bound_hits >= 4) begin
        filling    = !filling;
        bound_hits = 0;
      end
      send_request(kind, k, 1'b0, '0);
    end
    req.valid <= 1'b0;

    while (pending_rsps.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (err_cnt == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/skt_pkg.sv
rtl/core/skt_if.sv
rtl/core/sorted_key_table.sv
test/tb.sv
